// ===== rtl/gammatone_complex_filter_macros.svh =====
// assertion helpers used by the filter engine
`ifndef GAMMATONE_COMPLEX_FILTER_MACROS_SVH
`define GAMMATONE_COMPLEX_FILTER_MACROS_SVH

// condition holds in the same cycle
`define GTC_ASSERT_HOLDS(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition holds in the cycle after
`define GTC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/gtc_pkg.sv =====
package gtc_pkg;

    localparam int STATE_BITS    = 32;
    localparam int ORDER_BITS    = 4;
    localparam int DEFAULT_ORDER = 4;
    localparam int CFG_IDX_BITS  = 3;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_DECAY_GAIN   = 3'd0,
        CFG_ROT_COS      = 3'd1,
        CFG_ROT_SIN      = 3'd2,
        CFG_FILTER_ORDER = 3'd3,
        CFG_PHASE_COS    = 3'd4,
        CFG_PHASE_SIN    = 3'd5
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_ROT1,
        ST_ROT2,
        ST_ROUND,
        ST_GAIN,
        ST_LEAK,
        ST_WRITE,
        ST_OUT_MUL,
        ST_OUT_SUM
    } t_state;

    typedef struct packed {
        logic rd;
        logic wr;
    } t_mem_ctrl;

endpackage

// ===== rtl/gtc_cfg_regs.sv =====
module gtc_cfg_regs #(
    parameter int MAX_SECTIONS   = 10,
    parameter int COEF_FRAC_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [gtc_pkg::CFG_IDX_BITS-1:0]     i_cfg_index,
    input  logic [COEF_FRAC_BITS+1:0]            i_cfg_data,
    output logic [COEF_FRAC_BITS:0]              o_gain,
    output logic [COEF_FRAC_BITS:0]              o_gain_c,
    output logic signed [COEF_FRAC_BITS+1:0]     o_rot_cos,
    output logic signed [COEF_FRAC_BITS+1:0]     o_rot_sin,
    output logic signed [COEF_FRAC_BITS+1:0]     o_phase_cos,
    output logic signed [COEF_FRAC_BITS+1:0]     o_phase_sin,
    output logic [(MAX_SECTIONS > 1 ? $clog2(MAX_SECTIONS) : 1)-1:0] o_last
);

    localparam int AW = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
    localparam int GW = COEF_FRAC_BITS + 1;
    localparam int CW = COEF_FRAC_BITS + 2;
    localparam int OW = gtc_pkg::ORDER_BITS;

    localparam logic [GW-1:0]        G_ONE = {1'b1, {COEF_FRAC_BITS{1'b0}}};
    localparam logic signed [CW-1:0] C_ONE = {2'b01, {COEF_FRAC_BITS{1'b0}}};

    logic [GW-1:0]        r_gain;
    logic signed [CW-1:0] r_rot_cos;
    logic signed [CW-1:0] r_rot_sin;
    logic [OW-1:0]        r_order;
    logic signed [CW-1:0] r_phase_cos;
    logic signed [CW-1:0] r_phase_sin;

    logic [OW:0]          eff_order;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain      <= '0;
            r_rot_cos   <= C_ONE;
            r_rot_sin   <= '0;
            r_order     <= OW'(gtc_pkg::DEFAULT_ORDER);
            r_phase_cos <= C_ONE;
            r_phase_sin <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                gtc_pkg::CFG_DECAY_GAIN:   r_gain      <= i_cfg_data[GW-1:0];
                gtc_pkg::CFG_ROT_COS:      r_rot_cos   <= signed'(i_cfg_data);
                gtc_pkg::CFG_ROT_SIN:      r_rot_sin   <= signed'(i_cfg_data);
                gtc_pkg::CFG_FILTER_ORDER: r_order     <= i_cfg_data[OW-1:0];
                gtc_pkg::CFG_PHASE_COS:    r_phase_cos <= signed'(i_cfg_data);
                gtc_pkg::CFG_PHASE_SIN:    r_phase_sin <= signed'(i_cfg_data);
                default: ;
            endcase
        end
    end

    // gain above one is clamped to one
    always_comb begin
        o_gain   = (r_gain > G_ONE) ? G_ONE : r_gain;
        o_gain_c = G_ONE - o_gain;
    end

    // zero order means the default, and the count never exceeds the memory depth
    always_comb begin
        eff_order = (r_order == '0) ? (OW+1)'(gtc_pkg::DEFAULT_ORDER) : {1'b0, r_order};
        if (eff_order > (OW+1)'(MAX_SECTIONS)) begin
            eff_order = (OW+1)'(MAX_SECTIONS);
        end
        o_last = AW'(eff_order - (OW+1)'(1));
    end

    assign o_rot_cos   = r_rot_cos;
    assign o_rot_sin   = r_rot_sin;
    assign o_phase_cos = r_phase_cos;
    assign o_phase_sin = r_phase_sin;

endmodule

// ===== rtl/gtc_state_mem.sv =====
module gtc_state_mem #(
    parameter int MAX_SECTIONS = 10
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  gtc_pkg::t_mem_ctrl                    i_ctrl,
    input  logic [(MAX_SECTIONS > 1 ? $clog2(MAX_SECTIONS) : 1)-1:0] i_rd_addr,
    input  logic [(MAX_SECTIONS > 1 ? $clog2(MAX_SECTIONS) : 1)-1:0] i_wr_addr,
    input  logic signed [gtc_pkg::STATE_BITS-1:0] i_wr_real,
    input  logic signed [gtc_pkg::STATE_BITS-1:0] i_wr_imag,
    output logic signed [gtc_pkg::STATE_BITS-1:0] o_rd_real,
    output logic signed [gtc_pkg::STATE_BITS-1:0] o_rd_imag
);

    localparam int SW = gtc_pkg::STATE_BITS;

    logic [2*SW-1:0]         mem [MAX_SECTIONS];
    logic [MAX_SECTIONS-1:0] r_valid;
    logic [2*SW-1:0]         r_rd_word;
    logic                    r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr) begin
            mem[i_wr_addr] <= {i_wr_imag, i_wr_real};
        end
        if (i_ctrl.rd) begin
            r_rd_word <= mem[i_rd_addr];
        end
    end

    // an entry never written since reset reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_ctrl.wr) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_ctrl.rd) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_real = r_rd_valid ? signed'(r_rd_word[SW-1:0]) : '0;
    assign o_rd_imag = r_rd_valid ? signed'(r_rd_word[2*SW-1:SW]) : '0;

endmodule

// ===== rtl/gtc_engine.sv =====
`include "gammatone_complex_filter_macros.svh"

module gtc_engine #(
    parameter int MAX_SECTIONS   = 10,
    parameter int SAMPLE_BITS    = 24,
    parameter int COEF_FRAC_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0]         i_sample_in,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [SAMPLE_BITS-1:0]         o_sample_out,
    input  logic [COEF_FRAC_BITS:0]               i_gain,
    input  logic [COEF_FRAC_BITS:0]               i_gain_c,
    input  logic signed [COEF_FRAC_BITS+1:0]      i_rot_cos,
    input  logic signed [COEF_FRAC_BITS+1:0]      i_rot_sin,
    input  logic signed [COEF_FRAC_BITS+1:0]      i_phase_cos,
    input  logic signed [COEF_FRAC_BITS+1:0]      i_phase_sin,
    input  logic [(MAX_SECTIONS > 1 ? $clog2(MAX_SECTIONS) : 1)-1:0] i_last,
    output gtc_pkg::t_mem_ctrl                    o_mem_ctrl,
    output logic [(MAX_SECTIONS > 1 ? $clog2(MAX_SECTIONS) : 1)-1:0] o_rd_addr,
    output logic [(MAX_SECTIONS > 1 ? $clog2(MAX_SECTIONS) : 1)-1:0] o_wr_addr,
    output logic signed [gtc_pkg::STATE_BITS-1:0] o_wr_real,
    output logic signed [gtc_pkg::STATE_BITS-1:0] o_wr_imag,
    input  logic signed [gtc_pkg::STATE_BITS-1:0] i_rd_real,
    input  logic signed [gtc_pkg::STATE_BITS-1:0] i_rd_imag
);

    localparam int AW = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
    localparam int CW = COEF_FRAC_BITS + 2;
    localparam int SW = gtc_pkg::STATE_BITS;
    localparam int RW = CW + SW + 1 - COEF_FRAC_BITS;   // rotated value
    localparam int PW = RW + CW;                          // product

    localparam logic signed [PW:0] ONE_W     = (PW+1)'(1);
    localparam logic signed [PW:0] HALF_F    = ONE_W <<< (COEF_FRAC_BITS - 1);
    localparam logic signed [PW:0] HALF_O    = ONE_W <<< (COEF_FRAC_BITS - 2);
    localparam logic signed [PW:0] STATE_MAX = (ONE_W <<< (SW - 1)) - ONE_W;
    localparam logic signed [PW:0] STATE_MIN = -STATE_MAX - ONE_W;
    localparam logic signed [PW:0] SMP_MAX   = (ONE_W <<< (SAMPLE_BITS - 1)) - ONE_W;
    localparam logic signed [PW:0] SMP_MIN   = -SMP_MAX - ONE_W;

    gtc_pkg::t_state r_state;
    gtc_pkg::t_state n_state;

    logic [AW-1:0]          r_sec;
    logic signed [SW-1:0]   r_yi;
    logic signed [RW-1:0]   r_rr;
    logic signed [RW-1:0]   r_ri;
    logic signed [PW-1:0]   r_acc_r;
    logic signed [PW-1:0]   r_acc_i;
    logic signed [PW-1:0]   r_pa;
    logic signed [PW-1:0]   r_pb;
    logic signed [SW-1:0]   r_dr;
    logic signed [SW-1:0]   r_di;
    logic signed [SAMPLE_BITS-1:0] r_out;
    logic                   r_out_valid;

    logic                   is_last;
    logic                   load_out;
    logic signed [RW-1:0]   op_a_x;
    logic signed [CW-1:0]   op_a_y;
    logic signed [RW-1:0]   op_b_x;
    logic signed [CW-1:0]   op_b_y;
    logic signed [PW-1:0]   mul_a;
    logic signed [PW-1:0]   mul_b;
    logic signed [CW-1:0]   gain_s;
    logic signed [CW-1:0]   gain_c_s;

    logic signed [PW:0]     rot_sum_r;
    logic signed [PW:0]     rot_sum_i;
    logic signed [PW:0]     rot_rnd_r;
    logic signed [PW:0]     rot_rnd_i;
    logic signed [PW:0]     new_sum_r;
    logic signed [PW:0]     new_sum_i;
    logic signed [PW:0]     new_rnd_r;
    logic signed [PW:0]     new_rnd_i;
    logic signed [SW-1:0]   new_r;
    logic signed [SW-1:0]   new_i;
    logic signed [PW:0]     out_sum;
    logic signed [PW:0]     out_rnd;
    logic signed [SAMPLE_BITS-1:0] out_sat;

    assign is_last  = (r_sec == i_last);
    assign gain_s   = signed'({1'b0, i_gain});
    assign gain_c_s = signed'({1'b0, i_gain_c});

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            gtc_pkg::ST_IDLE:    if (i_in_valid) n_state = gtc_pkg::ST_READ;
            gtc_pkg::ST_READ:    n_state = gtc_pkg::ST_ROT1;
            gtc_pkg::ST_ROT1:    n_state = gtc_pkg::ST_ROT2;
            gtc_pkg::ST_ROT2:    n_state = gtc_pkg::ST_ROUND;
            gtc_pkg::ST_ROUND:   n_state = gtc_pkg::ST_GAIN;
            gtc_pkg::ST_GAIN:    n_state = gtc_pkg::ST_LEAK;
            gtc_pkg::ST_LEAK:    n_state = gtc_pkg::ST_WRITE;
            gtc_pkg::ST_WRITE: begin
                n_state = is_last ? gtc_pkg::ST_OUT_MUL : gtc_pkg::ST_ROT1;
            end
            gtc_pkg::ST_OUT_MUL: n_state = gtc_pkg::ST_OUT_SUM;
            gtc_pkg::ST_OUT_SUM: begin
                if (!r_out_valid || !i_out_stall) n_state = gtc_pkg::ST_IDLE;
            end
            default:             n_state = gtc_pkg::ST_IDLE;
        endcase
    end

    // control outputs; the next section is read while the current one is written back
    always_comb begin
        o_in_stall    = (r_state != gtc_pkg::ST_IDLE);
        o_mem_ctrl.rd = (r_state == gtc_pkg::ST_READ) ||
                        ((r_state == gtc_pkg::ST_WRITE) && !is_last);
        o_mem_ctrl.wr = (r_state == gtc_pkg::ST_WRITE);
        o_rd_addr     = (r_state == gtc_pkg::ST_READ) ? r_sec : AW'(r_sec + AW'(1));
        o_wr_addr     = r_sec;
        load_out      = (r_state == gtc_pkg::ST_OUT_SUM) && (!r_out_valid || !i_out_stall);
    end

    // operand select for the two multiplier lanes
    always_comb begin
        op_a_x = '0;
        op_a_y = '0;
        op_b_x = '0;
        op_b_y = '0;
        case (r_state)
            gtc_pkg::ST_ROT1: begin
                op_a_x = RW'(i_rd_real);
                op_a_y = i_rot_cos;
                op_b_x = RW'(i_rd_real);
                op_b_y = i_rot_sin;
            end
            gtc_pkg::ST_ROT2: begin
                op_a_x = RW'(r_yi);
                op_a_y = i_rot_sin;
                op_b_x = RW'(r_yi);
                op_b_y = i_rot_cos;
            end
            gtc_pkg::ST_GAIN: begin
                op_a_x = r_rr;
                op_a_y = gain_s;
                op_b_x = r_ri;
                op_b_y = gain_s;
            end
            gtc_pkg::ST_LEAK: begin
                op_a_x = RW'(r_dr);
                op_a_y = gain_c_s;
                op_b_x = RW'(r_di);
                op_b_y = gain_c_s;
            end
            gtc_pkg::ST_OUT_MUL: begin
                op_a_x = RW'(r_dr);
                op_a_y = i_phase_cos;
                op_b_x = RW'(r_di);
                op_b_y = i_phase_sin;
            end
            default: ;
        endcase
    end

    assign mul_a = op_a_x * op_a_y;
    assign mul_b = op_b_x * op_b_y;

    // rounding, saturation and output arithmetic
    always_comb begin
        rot_sum_r = (PW+1)'(r_acc_r) - (PW+1)'(r_pa);
        rot_sum_i = (PW+1)'(r_acc_i) + (PW+1)'(r_pb);
        rot_rnd_r = (rot_sum_r + HALF_F) >>> COEF_FRAC_BITS;
        rot_rnd_i = (rot_sum_i + HALF_F) >>> COEF_FRAC_BITS;

        new_sum_r = (PW+1)'(r_acc_r) + (PW+1)'(r_pa);
        new_sum_i = (PW+1)'(r_acc_i) + (PW+1)'(r_pb);
        new_rnd_r = (new_sum_r + HALF_F) >>> COEF_FRAC_BITS;
        new_rnd_i = (new_sum_i + HALF_F) >>> COEF_FRAC_BITS;
        if (new_rnd_r > STATE_MAX)      new_r = SW'(STATE_MAX);
        else if (new_rnd_r < STATE_MIN) new_r = SW'(STATE_MIN);
        else                            new_r = SW'(new_rnd_r);
        if (new_rnd_i > STATE_MAX)      new_i = SW'(STATE_MAX);
        else if (new_rnd_i < STATE_MIN) new_i = SW'(STATE_MIN);
        else                            new_i = SW'(new_rnd_i);

        // output scale is doubled, so one fraction bit fewer is dropped
        out_sum = (PW+1)'(r_pa) - (PW+1)'(r_pb);
        out_rnd = (out_sum + HALF_O) >>> (COEF_FRAC_BITS - 1);
        if (out_rnd > SMP_MAX)      out_sat = SAMPLE_BITS'(SMP_MAX);
        else if (out_rnd < SMP_MIN) out_sat = SAMPLE_BITS'(SMP_MIN);
        else                        out_sat = SAMPLE_BITS'(out_rnd);
    end

    assign o_wr_real = new_r;
    assign o_wr_imag = new_i;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gtc_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            gtc_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    r_dr  <= SW'(i_sample_in);
                    r_di  <= '0;
                    r_sec <= '0;
                end
            end
            gtc_pkg::ST_ROT1: begin
                r_yi <= i_rd_imag;
                r_pa <= mul_a;
                r_pb <= mul_b;
            end
            gtc_pkg::ST_ROT2, gtc_pkg::ST_LEAK: begin
                r_acc_r <= r_pa;
                r_acc_i <= r_pb;
                r_pa    <= mul_a;
                r_pb    <= mul_b;
            end
            gtc_pkg::ST_ROUND: begin
                r_rr <= RW'(rot_rnd_r);
                r_ri <= RW'(rot_rnd_i);
            end
            gtc_pkg::ST_GAIN, gtc_pkg::ST_OUT_MUL: begin
                r_pa <= mul_a;
                r_pb <= mul_b;
            end
            gtc_pkg::ST_WRITE: begin
                r_dr <= new_r;
                r_di <= new_i;
                if (!is_last) begin
                    r_sec <= AW'(r_sec + AW'(1));
                end
            end
            default: ;
        endcase
        if (load_out) begin
            r_out <= out_sat;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_out;

    `GTC_ASSERT_HOLDS(a_no_same_entry, o_mem_ctrl.rd && o_mem_ctrl.wr, o_rd_addr != o_wr_addr, "read and write hit the same entry")
    `GTC_ASSERT_HOLDS(a_sec_in_range, r_state != gtc_pkg::ST_IDLE, r_sec <= i_last, "section index past active count")
    `GTC_ASSERT_NEXT(a_accept_starts, i_in_valid && !o_in_stall, r_state == gtc_pkg::ST_READ && r_sec == '0, "accepted request did not start at section zero")
    `GTC_ASSERT_NEXT(a_result_posted, r_state == gtc_pkg::ST_OUT_SUM && n_state == gtc_pkg::ST_IDLE, o_out_valid, "finished request left no result")

endmodule

// ===== rtl/gammatone_complex_filter.sv =====
// channel   direction  valid        stall        payload
// input     in         i_in_valid   o_in_stall   i_sample_in
// output    out        o_out_valid  i_out_stall  o_sample_out
// config    in         i_cfg_we     (none)       i_cfg_index, i_cfg_data
//
// requests are taken one at a time; for N active sections, each request takes
// six steps per section on the shared two-lane multiplier and state memory
// synchronous active-low reset initialises control and config and clears the
// per-section valid bits, so section state reads as zero until first written
// a result waits in the output register while the next request is processed;
// only the final step holds if that register is still occupied
module gammatone_complex_filter #(
    parameter int MAX_SECTIONS   = 10,
    parameter int SAMPLE_BITS    = 24,
    parameter int COEF_FRAC_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0]      i_sample_in,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic signed [SAMPLE_BITS-1:0]      o_sample_out,
    input  logic                               i_cfg_we,
    input  logic [gtc_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [COEF_FRAC_BITS+1:0]          i_cfg_data
);

    localparam int AW = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
    localparam int GW = COEF_FRAC_BITS + 1;
    localparam int CW = COEF_FRAC_BITS + 2;
    localparam int SW = gtc_pkg::STATE_BITS;

    logic [GW-1:0]        gain;
    logic [GW-1:0]        gain_c;
    logic signed [CW-1:0] rot_cos;
    logic signed [CW-1:0] rot_sin;
    logic signed [CW-1:0] phase_cos;
    logic signed [CW-1:0] phase_sin;
    logic [AW-1:0]        last;

    gtc_pkg::t_mem_ctrl   mem_ctrl;
    logic [AW-1:0]        rd_addr;
    logic [AW-1:0]        wr_addr;
    logic signed [SW-1:0] wr_real;
    logic signed [SW-1:0] wr_imag;
    logic signed [SW-1:0] rd_real;
    logic signed [SW-1:0] rd_imag;

    gtc_cfg_regs #(
        .MAX_SECTIONS   (MAX_SECTIONS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_gain      (gain),
        .o_gain_c    (gain_c),
        .o_rot_cos   (rot_cos),
        .o_rot_sin   (rot_sin),
        .o_phase_cos (phase_cos),
        .o_phase_sin (phase_sin),
        .o_last      (last)
    );

    gtc_state_mem #(
        .MAX_SECTIONS (MAX_SECTIONS)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (mem_ctrl),
        .i_rd_addr (rd_addr),
        .i_wr_addr (wr_addr),
        .i_wr_real (wr_real),
        .i_wr_imag (wr_imag),
        .o_rd_real (rd_real),
        .o_rd_imag (rd_imag)
    );

    gtc_engine #(
        .MAX_SECTIONS   (MAX_SECTIONS),
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_sample_in  (i_sample_in),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_sample_out (o_sample_out),
        .i_gain       (gain),
        .i_gain_c     (gain_c),
        .i_rot_cos    (rot_cos),
        .i_rot_sin    (rot_sin),
        .i_phase_cos  (phase_cos),
        .i_phase_sin  (phase_sin),
        .i_last       (last),
        .o_mem_ctrl   (mem_ctrl),
        .o_rd_addr    (rd_addr),
        .o_wr_addr    (wr_addr),
        .o_wr_real    (wr_real),
        .o_wr_imag    (wr_imag),
        .i_rd_real    (rd_real),
        .i_rd_imag    (rd_imag)
    );

endmodule
